>>> src/pacc_pkg.sv
package pacc_pkg;

    // field widths
    localparam int FREQ_W   = 22;
    localparam int NYQ_W    = 21;
    localparam int SCALE_W  = 24;
    localparam int PHASE_W  = 32;
    localparam int PERIOD_W = 22;
    localparam int CFG_W    = 24;
    localparam int PROD_W   = FREQ_W + SCALE_W;

    // phase accumulator width default
    localparam int PHASE_BITS_DEF = 32;

    // reciprocal: period = 2^RECIP_LOG2 / |f|, one quotient bit per step
    localparam int RECIP_LOG2 = 20;
    localparam int DIV_STEPS  = RECIP_LOG2 + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(1 << RECIP_LOG2);

    // register reset values
    localparam logic [NYQ_W-1:0]   NYQ_RESET   = NYQ_W'(384000);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1431656);

    // register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NYQUIST    = 1'b0;
    localparam t_cfg_idx CFG_STEP_SCALE = 1'b1;

endpackage

>>> src/pacc_if.sv
interface pacc_freq_if import pacc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FREQ_W-1:0] frequency;

    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

interface pacc_res_if import pacc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [PHASE_W-1:0]  phase;
    logic signed [PERIOD_W-1:0] period;
    logic                       zero_frequency;

    modport source (output valid, output phase, output period, output zero_frequency,
                    input ready);
    modport sink   (input valid, input phase, input period, input zero_frequency,
                    output ready);
endinterface

interface pacc_cfg_if import pacc_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/phase_accumulator_with_period.sv
// Phase accumulator oscillator with period output. Each frequency request (signed, in
// sixteenths of a hertz) is clamped from above to nyquist_limit, multiplied by step_scale
// and shifted right by 8 with floor rounding to give the phase increment; the increment is
// added to a PHASE_BITS-wide accumulator that wraps modulo one turn both ways, and the top
// 32 bits come out as phase. period is 2^20 / f in signed Q6.16 seconds, truncated toward
// zero; a zero frequency gives period +2^20, sets zero_frequency and leaves the phase as is.
// A request is taken in at S_IDLE, S_MUL does the 22x24 multiply, S_DIV forms the reciprocal
// in a radix-2 restoring divider, one quotient bit per cycle, and S_FIN updates the
// accumulator and loads the result register once it is free. The input is not ready while a
// request is in flight; a finished result waits in its own register, so the next request
// can be taken before the previous result is read. Configuration writes are always taken.
module phase_accumulator_with_period
    import pacc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pacc_cfg_if.sink      i_cfg,
    pacc_freq_if.sink     i_freq,
    pacc_res_if.source    o_res
);

    // increment and output alignment for the chosen accumulator width
    localparam int STEP_RSHIFT = (PHASE_BITS < 40) ? (40 - PHASE_BITS) : 0;
    localparam int STEP_LSHIFT = (PHASE_BITS > 40) ? (PHASE_BITS - 40) : 0;
    localparam int OUT_RSHIFT  = (PHASE_BITS > 32) ? (PHASE_BITS - 32) : 0;
    localparam int OUT_LSHIFT  = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
    localparam int WIDE_W      = 64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [NYQ_W-1:0]   r_nyq;
    logic [SCALE_W-1:0] r_scale;

    // request context
    logic [FREQ_W-1:0]  r_mag;      // |clamped frequency|, up to 2^21
    logic               r_neg;
    logic [PROD_W-1:0]  r_prod;

    // divider
    logic [CNT_W-1:0]     r_cnt;
    logic [FREQ_W-1:0]    r_rem;
    logic [DIV_STEPS-1:0] r_quo;

    // accumulator and result register
    logic [PHASE_BITS-1:0] r_acc;
    logic                  r_out_valid;
    logic [PHASE_W-1:0]    r_phase;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_zero;

    // clamp of the incoming request
    logic signed [FREQ_W:0] w_f_ext;
    logic signed [FREQ_W:0] w_nyq_ext;
    logic signed [FREQ_W:0] w_clamped;
    logic        [FREQ_W:0] w_mag_ext;

    // divider step
    logic              w_div_bit;
    logic [FREQ_W-1:0] w_trial;
    logic              w_fits;

    // write-back
    logic signed [WIDE_W-1:0] w_sprod;
    logic signed [WIDE_W-1:0] w_step;
    logic [PHASE_BITS-1:0]    n_acc;
    logic [WIDE_W-1:0]        w_phase_wide;
    logic [PERIOD_W-1:0]      w_quo_ext;
    logic [PERIOD_W-1:0]      n_period;
    logic                     w_push;

    assign i_cfg.ready  = 1'b1;
    assign i_freq.ready = (r_state == S_IDLE);

    assign o_res.valid          = r_out_valid;
    assign o_res.phase          = r_phase;
    assign o_res.period         = r_period;
    assign o_res.zero_frequency = r_zero;

    // clamp from above only; negative frequencies pass through
    always_comb begin
        w_f_ext   = {i_freq.frequency[FREQ_W-1], i_freq.frequency};
        w_nyq_ext = $signed({2'b00, r_nyq});
        w_clamped = (w_f_ext > w_nyq_ext) ? w_nyq_ext : w_f_ext;
        w_mag_ext = w_clamped[FREQ_W] ? 23'(-w_clamped) : w_clamped;
    end

    // restoring divide of 2^20 by the magnitude, dividend bit 20 first
    always_comb begin
        w_div_bit = (r_cnt == CNT_W'(DIV_STEPS - 1));
        w_trial   = {r_rem[FREQ_W-2:0], w_div_bit};
        w_fits    = (w_trial >= r_mag);
    end

    // increment, floor shift, wrap and output alignment
    always_comb begin
        w_sprod = r_neg ? -$signed(WIDE_W'(r_prod)) : $signed(WIDE_W'(r_prod));
        w_step  = (w_sprod >>> STEP_RSHIFT) <<< STEP_LSHIFT;
        n_acc   = r_acc + w_step[PHASE_BITS-1:0];

        w_phase_wide = (WIDE_W'(n_acc) >> OUT_RSHIFT) << OUT_LSHIFT;

        w_quo_ext = PERIOD_W'(r_quo);
        if (r_mag == '0) begin
            n_period = PERIOD_MAX;
        end else if (r_neg) begin
            n_period = -w_quo_ext;
        end else begin
            n_period = w_quo_ext;
        end

        w_push = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nyq       <= NYQ_RESET;
            r_scale     <= SCALE_RESET;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_NYQUIST:    r_nyq   <= i_cfg.data[NYQ_W-1:0];
                    CFG_STEP_SCALE: r_scale <= i_cfg.data;
                    default:        ;
                endcase
            end

            // result register drains independently of the sequencer
            if (o_res.ready && !w_push) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_freq.valid) begin
                        r_mag   <= w_mag_ext[FREQ_W-1:0];
                        r_neg   <= w_clamped[FREQ_W];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_mag * r_scale;
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_fits ? (w_trial - r_mag) : w_trial;
                    r_quo <= {r_quo[DIV_STEPS-2:0], w_fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // commit the phase only when the result can be loaded
                    if (w_push) begin
                        r_acc       <= n_acc;
                        r_phase     <= w_phase_wide[PHASE_W-1:0];
                        r_period    <= n_period;
                        r_zero      <= (r_mag == '0);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a zero-frequency result always carries the saturated period
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_frequency) |-> (o_res.period == PERIOD_MAX))
        else $error("zero frequency result without saturated period");

    // partial remainder stays below the divisor during the divide
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_mag != '0) |-> (r_rem < r_mag))
        else $error("divider remainder out of range");

    // the accumulator moves only when a result is loaded
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_push |=> $stable(r_acc))
        else $error("phase accumulator changed without a result");

    // divider always runs its full count before write-back
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != '0) |=> (r_state == S_DIV))
        else $error("divider left early");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pacc_pkg::*;

    // timing and run shape
    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int REQ_CYCLES     = 24;     // block's own cycles per request
    localparam int IDLE_PCT       = 8;      // chance of an idle cycle on either side
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off, fills the block
    localparam int STALL_LIMIT    = 3000;   // cycles with no handshake before giving up
    localparam int RANDOM_PHASES  = 14;
    localparam int REQS_PER_PHASE = 50;
    localparam int HOLD_PHASE     = 3;
    localparam int CALM_PHASE     = 6;      // no idling on either side in this phase
    localparam int N_DIRECTED     = 30;

    // register value ranges of interest
    localparam logic [NYQ_W-1:0]   NYQ_TOP  = NYQ_W'(1536000);
    localparam logic [SCALE_W-1:0] SCALE_LO = SCALE_W'(300000);
    localparam logic [SCALE_W-1:0] SCALE_HI = SCALE_W'(8600000);

    // numerator of the reciprocal, one second in Q7.16 over sixteenths of a hertz
    localparam logic [FREQ_W:0] RECIP_NUM = (FREQ_W+1)'(1) << RECIP_LOG2;

    typedef struct packed {
        logic [PHASE_W-1:0]         phase;
        logic signed [PERIOD_W-1:0] period;
        logic                       zero_frequency;
    } t_osc_out;

    typedef enum logic {ROW_FREQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_cfg_idx                 reg_idx;
        logic [CFG_W-1:0]         cfg_data;
        logic signed [FREQ_W-1:0] freq;
        logic                     typed;     // want holds a hand-written result
        t_osc_out                 want;
    } t_row;

    // directed requests; results typed in only where they follow at a glance
    // from the reset state and the reset registers
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // zero frequency right after reset: phase still zero, period saturated
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd0, 1'b1, '{32'h0, PERIOD_MAX, 1'b1}},
        // smallest positive step, reset step_scale
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1, 1'b1, '{32'd5592, PERIOD_MAX, 1'b0}},
        // floor rounding of the negative step takes the phase below zero
        '{ROW_FREQ, CFG_NYQUIST, '0, -22'sd1, 1'b1, '{32'hFFFF_FFFF, -PERIOD_MAX, 1'b0}},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd0, 1'b1, '{32'hFFFF_FFFF, PERIOD_MAX, 1'b1}},
        // wrap past one turn
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1, 1'b1, '{32'd5591, PERIOD_MAX, 1'b0}},
        // field extremes, clamp at the reset nyquist limit
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sh1FFFFF, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sh200000, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd384000, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd384001, 1'b0, '0},
        // period truncation around 2^20; the positive request clamps at the reset nyquist limit
        '{ROW_FREQ, CFG_NYQUIST, '0, -22'sd1048577, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, -22'sd1048576, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1048576, 1'b0, '0},
        // nyquist beyond its range, upper data bits masked off
        '{ROW_CFG, CFG_NYQUIST, 24'hFF_FFFF, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sh1FFFFF, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1048577, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd3, 1'b0, '0},
        // zero step_scale freezes the phase
        '{ROW_CFG, CFG_STEP_SCALE, 24'h00_0000, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd12345, 1'b0, '0},
        // zero nyquist: every positive frequency clamps to zero
        '{ROW_CFG, CFG_NYQUIST, 24'hE0_0000, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd5, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, -22'sd5, 1'b0, '0},
        // largest step_scale, top of the nyquist range
        '{ROW_CFG, CFG_STEP_SCALE, 24'hFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, CFG_NYQUIST, 24'd1536000, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1536000, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, -22'sd1536000, 1'b0, '0},
        // step_scale extremes of its range, alternating frequency bits
        '{ROW_CFG, CFG_STEP_SCALE, 24'd300000, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sh155555, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sh2AAAAA, 1'b0, '0},
        '{ROW_CFG, CFG_STEP_SCALE, 24'd8600000, '0, 1'b0, '0},
        '{ROW_FREQ, CFG_NYQUIST, '0, 22'sd1536001, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pacc_cfg_if  cfg_ch ();
    pacc_freq_if freq_ch ();
    pacc_res_if  res_ch ();

    phase_accumulator_with_period dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_freq  (freq_ch),
        .o_res   (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state: accumulator and the two registers as the block holds them
    logic [PHASE_W-1:0] acc_phase;
    logic [NYQ_W-1:0]   nyq_limit;
    logic [SCALE_W-1:0] scale;

    t_osc_out osc_due[$];          // results owed by the block, oldest first
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    logic     calm         = 1'b0;
    logic     hold_req     = 1'b0;

    // one request through the oscillator: clamp, step, wrap, reciprocal
    function automatic t_osc_out oscillator_step(input logic signed [FREQ_W-1:0] f_in);
        logic signed [FREQ_W:0]   f;
        logic signed [FREQ_W:0]   limit;
        logic [FREQ_W:0]          mag;
        logic signed [PROD_W+1:0] prod;
        logic [FREQ_W:0]          quot;
        t_osc_out                 r;
        f     = f_in;
        limit = {2'b00, nyq_limit};
        // upper clamp only, negative frequencies pass
        if (f > limit)
            f = limit;
        mag  = (f < 0) ? -f : f;
        prod = mag * scale;
        if (f < 0)
            prod = -prod;
        // arithmetic shift rounds the negative step toward minus infinity
        acc_phase = acc_phase + PHASE_W'(prod >>> (40 - PHASE_W));
        r.phase          = acc_phase;
        r.zero_frequency = (mag == 0);
        if (mag == 0) begin
            r.period = PERIOD_MAX;
        end else begin
            quot     = RECIP_NUM / mag;
            r.period = PERIOD_W'((f < 0) ? -quot : quot);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // offer one frequency request, idling at random first; valid stays high
    // after acceptance so back-to-back requests need no extra edge
    task automatic send_freq(input logic signed [FREQ_W-1:0] f, input logic typed,
                             input t_osc_out want);
        t_osc_out predicted;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            freq_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        freq_ch.valid     <= 1'b1;
        freq_ch.frequency <= f;
        @(posedge i_clk);
        while (!freq_ch.ready)
            @(posedge i_clk);
        predicted = oscillator_step(f);
        osc_due.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait until every owed result has been read
    task automatic drain();
        @(negedge i_clk);
        freq_ch.valid <= 1'b0;
        while (osc_due.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, only issued with the block idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        if (idx == CFG_NYQUIST)
            nyq_limit = data[NYQ_W-1:0];
        else
            scale = data[SCALE_W-1:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus: reset, directed table, then random phases with fresh registers
    initial begin : stimulus
        int                       p;
        int                       n;
        int                       fv;
        logic [NYQ_W-1:0]         nyq_val;
        logic [SCALE_W-1:0]       scale_val;
        i_rst_n           = 1'b0;
        freq_ch.valid     = 1'b0;
        freq_ch.frequency = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_NYQUIST;
        cfg_ch.data       = '0;
        acc_phase         = '0;
        nyq_limit         = NYQ_RESET;
        scale             = SCALE_RESET;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                drain();
                write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].cfg_data);
            end else begin
                send_freq(DIRECTED_ROWS[i].freq, DIRECTED_ROWS[i].typed,
                          DIRECTED_ROWS[i].want);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            calm = (p == CALM_PHASE);
            // nyquist: zero, top of range, all ones, anything, or within the range
            case ($urandom_range(5))
                0:       nyq_val = '0;
                1:       nyq_val = NYQ_TOP;
                2:       nyq_val = '1;
                3:       nyq_val = NYQ_W'($urandom);
                default: nyq_val = NYQ_W'($urandom_range(NYQ_TOP));
            endcase
            // unused upper data bits carry noise
            write_reg(CFG_NYQUIST, {3'($urandom), nyq_val});
            case ($urandom_range(6))
                0:       scale_val = SCALE_LO;
                1:       scale_val = SCALE_HI;
                2:       scale_val = '0;
                3:       scale_val = '1;
                default: scale_val = SCALE_W'($urandom_range(SCALE_HI, SCALE_LO));
            endcase
            write_reg(CFG_STEP_SCALE, scale_val);

            for (n = 0; n < REQS_PER_PHASE; n++) begin
                // receiver holds off while requests keep coming
                if (p == HOLD_PHASE && n == 10)
                    hold_req = 1'b1;
                case ($urandom_range(9))
                    0: fv = $urandom;
                    1: fv = int'($urandom_range(32)) - 16;
                    // around the clamp, both signs
                    2: fv = int'(nyq_limit) + int'($urandom_range(8)) - 4;
                    3: fv = -int'(nyq_limit) + int'($urandom_range(8)) - 4;
                    // field ends and the period truncation edge
                    4: begin
                        case ($urandom_range(3))
                            0:       fv = 2097151;
                            1:       fv = -2097152;
                            2:       fv = 1048576;
                            default: fv = -1048576;
                        endcase
                        fv += int'($urandom_range(2)) - 1;
                    end
                    default: fv = int'($urandom_range(3072000)) - 1536000;
                endcase
                send_freq(FREQ_W'(fv), 1'b0, '0);
            end
        end

        drain();
        repeat (2 * REQ_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("phase_accumulator_with_period test passed");
        else
            $display("phase_accumulator_with_period test failed");
        $finish;
    end

    // result side: random idling, one long hold-off on request
    initial begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each accepted result with the oldest owed one
    always @(posedge i_clk) begin : check_results
        t_osc_out due;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (osc_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed, phase %h", res_ch.phase));
            end else begin
                due = osc_due.pop_front();
                if (res_ch.phase !== due.phase)
                    report_mismatch($sformatf("phase %h, predicted %h",
                                              res_ch.phase, due.phase));
                if (res_ch.period !== due.period)
                    report_mismatch($sformatf("period %0d, predicted %0d",
                                              $signed(res_ch.period), $signed(due.period)));
                if (res_ch.zero_frequency !== due.zero_frequency)
                    report_mismatch($sformatf("zero_frequency %b, predicted %b",
                                              res_ch.zero_frequency, due.zero_frequency));
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (freq_ch.valid && freq_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("phase_accumulator_with_period test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
